// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the checker files of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Immediate implication: when the antecedent holds, the consequent holds in the same cycle.
`define ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("%m: assertion failed");

// Next-cycle implication: when the antecedent holds, the consequent holds in the next cycle.
`define ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("%m: assertion failed");

`endif

// ===== rtl/crfa_pkg.sv =====
// Shared constants, widths and the arctangent table of the fixed-angle CORDIC rotator.
package crfa_pkg;

    localparam int ITERATIONS_DEF = 30;
    localparam int DATA_WIDTH_DEF = 32;

    localparam int IN_W       = 30;
    localparam int ANGLE_W    = 32;
    localparam int OUT_W      = 31;
    localparam int S_TDATA_W  = 96;
    localparam int M_TDATA_W  = 64;
    localparam int ATAN_IDX_W = 5;
    localparam int GAIN_W     = 31;

    // Gain correction 0.6072529350 as unsigned Q0.31.
    localparam logic [GAIN_W-1:0] GAIN_Q031 = 31'h4DBA76D4;

    // atan(2^-i) scaled so that 2^29 is pi/4.
    function automatic logic [ANGLE_W-1:0] atan_step(input logic [ATAN_IDX_W-1:0] idx);
        logic [ANGLE_W-1:0] v;
        case (idx)
            5'd0:    v = 32'h20000000;
            5'd1:    v = 32'h12E4051D;
            5'd2:    v = 32'h09FB385B;
            5'd3:    v = 32'h051111D4;
            5'd4:    v = 32'h028B0D43;
            5'd5:    v = 32'h0145D7E1;
            5'd6:    v = 32'h00A2F61E;
            5'd7:    v = 32'h00517C55;
            5'd8:    v = 32'h0028BE53;
            5'd9:    v = 32'h00145F2E;
            5'd10:   v = 32'h000A2F98;
            5'd11:   v = 32'h000517CC;
            5'd12:   v = 32'h00028BE6;
            5'd13:   v = 32'h000145F3;
            5'd14:   v = 32'h0000A2F9;
            5'd15:   v = 32'h0000517C;
            5'd16:   v = 32'h000028BE;
            5'd17:   v = 32'h0000145F;
            5'd18:   v = 32'h00000A2F;
            5'd19:   v = 32'h00000517;
            5'd20:   v = 32'h0000028B;
            5'd21:   v = 32'h00000145;
            5'd22:   v = 32'h000000A2;
            5'd23:   v = 32'h00000051;
            5'd24:   v = 32'h00000028;
            5'd25:   v = 32'h00000014;
            5'd26:   v = 32'h0000000A;
            5'd27:   v = 32'h00000005;
            5'd28:   v = 32'h00000002;
            5'd29:   v = 32'h00000001;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/cordic_rotate_fixed_angle.sv =====
// Top level of the fixed-angle CORDIC rotator: sequencer, shared rotator and gain unit.
//
// The s_ channel takes one request: x_value, y_value (30-bit signed) and turn_angle
// (32-bit binary angle, 2^32 is one turn). The m_ channel returns one result per
// request: x_rotated and y_rotated, 31-bit signed, gain-corrected and truncated
// toward zero.
// A request is taken only while s_tready is high. One micro-rotation runs per cycle
// on the shared rotator, ITERATIONS of them in all, then the single gain multiplier
// handles x and then y, and a final store step writes the output register.
// s_tready returns in the same cycle as m_tvalid rises, so no new request is taken
// while a request is being computed.
// The output register holds a finished result while the next request is computed.
// If the receiver is still stalling when the next result is done, the sequencer
// waits in its store step and takes no new request until the register frees up.
// A synchronous active-low reset returns the sequencer to idle and clears m_tvalid.
module cordic_rotate_fixed_angle #(
    parameter int ITERATIONS = crfa_pkg::ITERATIONS_DEF,
    parameter int DATA_WIDTH = crfa_pkg::DATA_WIDTH_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // s_tdata from bit 0: x_value[29:0], y_value[59:30], turn_angle[91:60], zero fill.
    input  logic [crfa_pkg::S_TDATA_W-1:0]   s_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // m_tdata from bit 0: x_rotated[30:0], y_rotated[61:31], zero fill.
    output logic [crfa_pkg::M_TDATA_W-1:0]   m_tdata
);

    localparam int ITER_W = $clog2(ITERATIONS);
    localparam int IW     = crfa_pkg::IN_W;
    localparam int AW     = crfa_pkg::ANGLE_W;
    localparam int OW     = crfa_pkg::OUT_W;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_ITER   = 3'd1;
    localparam logic [2:0] ST_GAIN_X = 3'd2;
    localparam logic [2:0] ST_GAIN_Y = 3'd3;
    localparam logic [2:0] ST_STORE  = 3'd4;

    logic [2:0]                  state_reg, state_next;
    logic [ITER_W-1:0]           iter_reg;
    logic signed [DATA_WIDTH-1:0] x_reg, y_reg;
    logic signed [AW-1:0]        err_reg;
    logic                        fold_reg;
    logic [OW-1:0]               x_out_reg;
    logic                        m_tvalid_reg;
    logic [crfa_pkg::M_TDATA_W-1:0] m_tdata_reg;

    logic signed [DATA_WIDTH-1:0] x_rot, y_rot;
    logic signed [AW-1:0]        err_rot;
    logic [IW-1:0]               in_x, in_y;
    logic [AW-1:0]               in_ang;
    logic [AW-1:0]               x_ext, y_ext;
    logic                        in_fold;
    logic                        s_accept, out_free, gain_en;
    logic signed [DATA_WIDTH-1:0] gain_value;
    logic [DATA_WIDTH-1:0]       gain_mag;
    logic                        gain_neg;
    logic [AW-1:0]               mag_ext, signed_res;

    assign in_x    = s_tdata[IW-1:0];
    assign in_y    = s_tdata[2*IW-1:IW];
    assign in_ang  = s_tdata[2*IW+AW-1:2*IW];
    assign x_ext   = {{(AW-IW){in_x[IW-1]}}, in_x};
    assign y_ext   = {{(AW-IW){in_y[IW-1]}}, in_y};
    assign in_fold = in_ang[AW-1] ^ in_ang[AW-2];

    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    crfa_rotator #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_rotator (
        .x_in    (x_reg),
        .y_in    (y_reg),
        .err_in  (err_reg),
        .step    (crfa_pkg::ATAN_IDX_W'(iter_reg)),
        .x_out   (x_rot),
        .y_out   (y_rot),
        .err_out (err_rot)
    );

    assign gain_en    = (state_reg == ST_GAIN_X) || (state_reg == ST_GAIN_Y);
    assign gain_value = (state_reg == ST_GAIN_X) ? x_reg : y_reg;

    crfa_gain #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_gain (
        .aclk    (aclk),
        .en      (gain_en),
        .value   (gain_value),
        .fold    (fold_reg),
        .mag_reg (gain_mag),
        .neg_reg (gain_neg)
    );

    // Sign of the folded and gain-corrected value, cut to the output width.
    assign mag_ext    = AW'(gain_mag);
    assign signed_res = gain_neg ? (-mag_ext) : mag_ext;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    state_next = ST_ITER;
                end
            end
            ST_ITER: begin
                if (iter_reg == ITER_W'(ITERATIONS - 1)) begin
                    state_next = ST_GAIN_X;
                end
            end
            ST_GAIN_X: state_next = ST_GAIN_Y;
            ST_GAIN_Y: state_next = ST_STORE;
            ST_STORE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
            iter_reg     <= '0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_STORE && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            if (s_accept) begin
                iter_reg <= '0;
            end else if (state_reg == ST_ITER) begin
                iter_reg <= iter_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            x_reg    <= signed'(x_ext[DATA_WIDTH-1:0]);
            y_reg    <= signed'(y_ext[DATA_WIDTH-1:0]);
            // Second and third quadrants are moved by pi through the top bit.
            err_reg  <= signed'({in_ang[AW-1] ^ in_fold, in_ang[AW-2:0]});
            fold_reg <= in_fold;
        end else if (state_reg == ST_ITER) begin
            x_reg   <= x_rot;
            y_reg   <= y_rot;
            err_reg <= err_rot;
        end
        if (state_reg == ST_GAIN_Y) begin
            x_out_reg <= signed_res[OW-1:0];
        end
        if (state_reg == ST_STORE && out_free) begin
            m_tdata_reg <= {{(crfa_pkg::M_TDATA_W-2*OW){1'b0}}, signed_res[OW-1:0], x_out_reg};
        end
    end

endmodule

// ===== rtl/crfa_rotator.sv =====
// One CORDIC micro-rotation: shift-add on x and y, residual angle update.
module crfa_rotator #(
    parameter int DATA_WIDTH = crfa_pkg::DATA_WIDTH_DEF
) (
    input  logic signed [DATA_WIDTH-1:0]        x_in,
    input  logic signed [DATA_WIDTH-1:0]        y_in,
    input  logic signed [crfa_pkg::ANGLE_W-1:0] err_in,
    input  logic [crfa_pkg::ATAN_IDX_W-1:0]     step,
    output logic signed [DATA_WIDTH-1:0]        x_out,
    output logic signed [DATA_WIDTH-1:0]        y_out,
    output logic signed [crfa_pkg::ANGLE_W-1:0] err_out
);

    logic signed [DATA_WIDTH-1:0]        x_sh;
    logic signed [DATA_WIDTH-1:0]        y_sh;
    logic signed [crfa_pkg::ANGLE_W-1:0] angle;
    logic                                rot_pos;

    assign x_sh    = x_in >>> step;
    assign y_sh    = y_in >>> step;
    assign angle   = signed'(crfa_pkg::atan_step(step));
    assign rot_pos = !err_in[crfa_pkg::ANGLE_W-1];

    always_comb begin
        if (rot_pos) begin
            x_out   = x_in - y_sh;
            y_out   = y_in + x_sh;
            err_out = err_in - angle;
        end else begin
            x_out   = x_in + y_sh;
            y_out   = y_in - x_sh;
            err_out = err_in + angle;
        end
    end

endmodule

// ===== rtl/crfa_gain.sv =====
// Gain correction unit: magnitude times the Q0.31 gain, registered with the result sign.
module crfa_gain #(
    parameter int DATA_WIDTH = crfa_pkg::DATA_WIDTH_DEF
) (
    input  logic                         aclk,
    input  logic                         en,
    input  logic signed [DATA_WIDTH-1:0] value,
    input  logic                         fold,
    output logic [DATA_WIDTH-1:0]        mag_reg,
    output logic                         neg_reg
);

    localparam int PROD_W = DATA_WIDTH + crfa_pkg::GAIN_W;

    logic [DATA_WIDTH-1:0] mag;
    logic [PROD_W-1:0]     prod;

    // The most negative value wraps to its own magnitude as an unsigned number.
    assign mag  = value[DATA_WIDTH-1] ? unsigned'(-value) : unsigned'(value);
    assign prod = PROD_W'(mag) * PROD_W'(crfa_pkg::GAIN_Q031);

    always_ff @(posedge aclk) begin
        if (en) begin
            mag_reg <= prod[PROD_W-1:crfa_pkg::GAIN_W];
            neg_reg <= value[DATA_WIDTH-1] ^ fold;
        end
    end

endmodule

// ===== rtl/crfa_checker.sv =====
// Port-level checker for the fixed-angle CORDIC rotator, bound to its top level.
`include "assert_macros.svh"

module crfa_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [crfa_pkg::M_TDATA_W-1:0] m_tdata
);

    logic s_accept;
    logic m_stall;

    assign s_accept  = s_tvalid && s_tready;
    assign m_stall   = m_tvalid && !m_tready;

    // A taken request keeps the block busy in the following cycle.
    `ASSERT_NEXT(a_busy_after_request, aclk, aresetn, s_accept, !s_tready)
    // A new result appears only at the end of a computation, never while idle.
    `ASSERT_SAME(a_result_from_busy, aclk, aresetn, $rose(m_tvalid), $past(!s_tready))
    `ASSERT_NEXT(a_valid_holds, aclk, aresetn, m_stall, m_tvalid)
    `ASSERT_NEXT(a_data_holds, aclk, aresetn, m_stall, $stable(m_tdata))

endmodule

bind cordic_rotate_fixed_angle crfa_checker u_crfa_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
